>>> sv/lmh_pkg.sv
// Shared types and constants for the linked min-heap block.
// Used by lmh_ctrl, lmh_dp and linked_min_heap; no dependencies.
package lmh_pkg;

	localparam int DEPTH   = 1024;
	localparam int AW      = 10;
	localparam int KEY_W   = 24;
	localparam int PAY_W   = 64;
	localparam int LNK_W   = 11;
	localparam int N_W     = 11;
	localparam int IN_W    = 136;
	localparam int OUT_W   = 120;

	// command codes
	localparam logic [2:0] CMD_WRITE   = 3'd0;
	localparam logic [2:0] CMD_READ    = 3'd1;
	localparam logic [2:0] CMD_SETKEY  = 3'd2;
	localparam logic [2:0] CMD_SETLINK = 3'd3;
	localparam logic [2:0] CMD_SIFTUP  = 3'd4;
	localparam logic [2:0] CMD_RESTORE = 3'd5;

	// datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_WR_ENTRY = 4'd2;
	localparam logic [3:0] OP_WR_KEY   = 4'd3;
	localparam logic [3:0] OP_WR_LINKS = 4'd4;
	localparam logic [3:0] OP_SET_LAST = 4'd5;
	localparam logic [3:0] OP_READ     = 4'd6;
	localparam logic [3:0] OP_OTH_PAR  = 4'd7;
	localparam logic [3:0] OP_OTH_L    = 4'd8;
	localparam logic [3:0] OP_OTH_R    = 4'd9;
	localparam logic [3:0] OP_LNK1     = 4'd10;
	localparam logic [3:0] OP_LNK2     = 4'd11;
	localparam logic [3:0] OP_LNK3     = 4'd12;
	localparam logic [3:0] OP_LNK4     = 4'd13;
	localparam logic [3:0] OP_XCHG1    = 4'd14;
	localparam logic [3:0] OP_XCHG2    = 4'd15;

	// read address selects
	localparam logic [2:0] RS_CUR   = 3'd0;
	localparam logic [2:0] RS_PAR   = 3'd1;
	localparam logic [2:0] RS_LEFT  = 3'd2;
	localparam logic [2:0] RS_RIGHT = 3'd3;
	localparam logic [2:0] RS_OTH   = 3'd4;

	// read capture destinations
	localparam logic [1:0] DST_A = 2'd0;
	localparam logic [1:0] DST_B = 2'd1;
	localparam logic [1:0] DST_L = 2'd2;
	localparam logic [1:0] DST_R = 2'd3;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] rsel;
		logic [1:0] dst;
		logic       out_load;
	} lmh_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       n_zero;
		logic       pos_lt_n;
		logic       cur_zero;
		logic       left_lt_n;
		logic       right_lt_n;
		logic       a_gt_b;
		logic       a_lt_b;
		logic       a_gt_l;
		logic       a_gt_r;
		logic       l_lt_r;
	} lmh_stat_t;

endpackage

>>> sv/lmh_dp.sv
// Datapath of the linked min-heap: entry memories, working registers,
// link redirect and exchange writes, result register. Depends on lmh_pkg.
module lmh_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lmh_pkg::IN_W-1:0]    in_data,
	input  lmh_pkg::lmh_cmd_t           cmd,
	output lmh_pkg::lmh_stat_t          stat,
	output logic [lmh_pkg::OUT_W-1:0]   out_data
);

	// entry memories
	logic signed [lmh_pkg::KEY_W-1:0] key_mem  [lmh_pkg::DEPTH];
	logic        [lmh_pkg::PAY_W-1:0] pay_mem  [lmh_pkg::DEPTH];
	logic        [lmh_pkg::LNK_W-1:0] prev_mem [lmh_pkg::DEPTH];
	logic        [lmh_pkg::LNK_W-1:0] next_mem [lmh_pkg::DEPTH];

	logic [2:0]                  cmd_q;
	logic [lmh_pkg::AW-1:0]      cur_q, oth_q;
	logic [lmh_pkg::N_W-1:0]     n_q;
	logic signed [lmh_pkg::KEY_W-1:0] ikey_q;
	logic [lmh_pkg::PAY_W-1:0]   ipay_q;
	logic [lmh_pkg::LNK_W-1:0]   iprev_q, inext_q;

	logic signed [lmh_pkg::KEY_W-1:0] akey_q, bkey_q, lkey_q, rkey_q;
	logic [lmh_pkg::PAY_W-1:0]   apay_q, bpay_q;
	logic [lmh_pkg::LNK_W-1:0]   aprev_q, anext_q, bprev_q, bnext_q;

	logic signed [lmh_pkg::KEY_W-1:0] rkey_s1;
	logic [lmh_pkg::PAY_W-1:0]   rpay_s1;
	logic [lmh_pkg::LNK_W-1:0]   rprev_s1, rnext_s1;
	logic                        rvld_s1;
	logic [1:0]                  rdst_s1;

	logic [lmh_pkg::OUT_W-1:0]   out_q;

	logic [lmh_pkg::AW-1:0]      par, left_a, right_a, raddr, waddr;
	logic [lmh_pkg::N_W-1:0]     left_w, n_in;
	logic [lmh_pkg::N_W:0]       right_w;
	logic                        we_key, we_pay, we_prev, we_next, rd_en;
	logic signed [lmh_pkg::KEY_W-1:0] wkey;
	logic [lmh_pkg::PAY_W-1:0]   wpay;
	logic [lmh_pkg::LNK_W-1:0]   wprev, wnext;
	logic [lmh_pkg::LNK_W-1:0]   anext_cur;

	assign par     = (cur_q - lmh_pkg::AW'(1)) >> 1;
	assign left_w  = {cur_q, 1'b1};
	assign right_w = {1'b0, cur_q, 1'b0} + (lmh_pkg::N_W+1)'(2);
	assign left_a  = left_w[lmh_pkg::AW-1:0];
	assign right_a = right_w[lmh_pkg::AW-1:0];
	assign n_in    = in_data[23:13];
	assign rd_en   = (cmd.op == lmh_pkg::OP_READ);

	// next link of the current entry as left by the first redirect (self link case)
	assign anext_cur = (!aprev_q[lmh_pkg::LNK_W-1] && aprev_q[lmh_pkg::AW-1:0] == cur_q) ?
	                   {1'b0, oth_q} : anext_q;

	always_comb begin
		case (cmd.rsel)
			lmh_pkg::RS_PAR:   raddr = par;
			lmh_pkg::RS_LEFT:  raddr = left_a;
			lmh_pkg::RS_RIGHT: raddr = right_a;
			lmh_pkg::RS_OTH:   raddr = oth_q;
			default:           raddr = cur_q;
		endcase
	end

	// write port; a link whose sign bit is set names no entry
	always_comb begin
		we_key  = 1'b0;
		we_pay  = 1'b0;
		we_prev = 1'b0;
		we_next = 1'b0;
		waddr   = cur_q;
		wkey    = ikey_q;
		wpay    = ipay_q;
		wprev   = iprev_q;
		wnext   = inext_q;
		case (cmd.op)
			lmh_pkg::OP_WR_ENTRY: begin
				we_key = 1'b1; we_pay = 1'b1; we_prev = 1'b1; we_next = 1'b1;
			end
			lmh_pkg::OP_WR_KEY:   we_key = 1'b1;
			lmh_pkg::OP_WR_LINKS: begin
				we_prev = 1'b1; we_next = 1'b1;
			end
			lmh_pkg::OP_LNK1: begin
				we_next = ~aprev_q[lmh_pkg::LNK_W-1];
				waddr   = aprev_q[lmh_pkg::AW-1:0];
				wnext   = {1'b0, oth_q};
			end
			lmh_pkg::OP_LNK2: begin
				we_prev = ~anext_cur[lmh_pkg::LNK_W-1];
				waddr   = anext_cur[lmh_pkg::AW-1:0];
				wprev   = {1'b0, oth_q};
			end
			lmh_pkg::OP_LNK3: begin
				we_next = ~bprev_q[lmh_pkg::LNK_W-1];
				waddr   = bprev_q[lmh_pkg::AW-1:0];
				wnext   = {1'b0, cur_q};
			end
			lmh_pkg::OP_LNK4: begin
				we_prev = ~bnext_q[lmh_pkg::LNK_W-1];
				waddr   = bnext_q[lmh_pkg::AW-1:0];
				wprev   = {1'b0, cur_q};
			end
			lmh_pkg::OP_XCHG1: begin
				we_key = 1'b1; we_pay = 1'b1; we_prev = 1'b1; we_next = 1'b1;
				waddr = oth_q;
				wkey = akey_q; wpay = apay_q; wprev = aprev_q; wnext = anext_q;
			end
			lmh_pkg::OP_XCHG2: begin
				we_key = 1'b1; we_pay = 1'b1; we_prev = 1'b1; we_next = 1'b1;
				wkey = bkey_q; wpay = bpay_q; wprev = bprev_q; wnext = bnext_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_key)  key_mem[waddr]  <= wkey;
		if (we_pay)  pay_mem[waddr]  <= wpay;
		if (we_prev) prev_mem[waddr] <= wprev;
		if (we_next) next_mem[waddr] <= wnext;
		if (rd_en) begin
			rkey_s1  <= key_mem[raddr];
			rpay_s1  <= pay_mem[raddr];
			rprev_s1 <= prev_mem[raddr];
			rnext_s1 <= next_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			rdst_s1 <= lmh_pkg::DST_A;
		end else begin
			rvld_s1 <= rd_en;
			rdst_s1 <= cmd.dst;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			case (rdst_s1)
				lmh_pkg::DST_A: begin
					akey_q <= rkey_s1; apay_q <= rpay_s1;
					aprev_q <= rprev_s1; anext_q <= rnext_s1;
				end
				lmh_pkg::DST_B: begin
					bkey_q <= rkey_s1; bpay_q <= rpay_s1;
					bprev_q <= rprev_s1; bnext_q <= rnext_s1;
				end
				lmh_pkg::DST_L: lkey_q <= rkey_s1;
				default:        rkey_q <= rkey_s1;
			endcase
		end
		case (cmd.op)
			lmh_pkg::OP_LOAD: begin
				cmd_q   <= in_data[2:0];
				cur_q   <= in_data[12:3];
				n_q     <= (n_in > lmh_pkg::N_W'(lmh_pkg::DEPTH)) ?
				           lmh_pkg::N_W'(lmh_pkg::DEPTH) : n_in;
				ikey_q  <= in_data[47:24];
				ipay_q  <= in_data[111:48];
				iprev_q <= in_data[122:112];
				inext_q <= in_data[133:123];
			end
			lmh_pkg::OP_SET_LAST: begin
				cur_q <= lmh_pkg::AW'(n_q - lmh_pkg::N_W'(1));
			end
			lmh_pkg::OP_OTH_PAR: oth_q <= par;
			lmh_pkg::OP_OTH_L:   oth_q <= left_a;
			lmh_pkg::OP_OTH_R:   oth_q <= right_a;
			lmh_pkg::OP_XCHG2:   cur_q <= oth_q;
			default: ;
		endcase
		if (cmd.out_load)
			out_q <= {cur_q, anext_q, aprev_q, apay_q, akey_q};
	end

	assign out_data = out_q;

	always_comb begin
		stat.cmd        = cmd_q;
		stat.n_zero     = (n_q == '0);
		stat.pos_lt_n   = ({1'b0, cur_q} < n_q);
		stat.cur_zero   = (cur_q == '0);
		stat.left_lt_n  = (left_w < n_q);
		stat.right_lt_n = (right_w < {1'b0, n_q});
		stat.a_gt_b     = (akey_q > bkey_q);
		stat.a_lt_b     = (akey_q < bkey_q);
		stat.a_gt_l     = (akey_q > lkey_q);
		stat.a_gt_r     = (akey_q > rkey_q);
		stat.l_lt_r     = (lkey_q < rkey_q);
	end

endmodule

>>> sv/lmh_ctrl.sv
// Sequencer of the linked min-heap: command dispatch, sift walks,
// swap sequence and result handshake. Depends on lmh_pkg.
module lmh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  lmh_pkg::lmh_stat_t  stat,
	output lmh_pkg::lmh_cmd_t   cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_UP_RA  = 5'd2;
	localparam logic [4:0] S_UP_RB  = 5'd3;
	localparam logic [4:0] S_UP_W   = 5'd4;
	localparam logic [4:0] S_UP_CMP = 5'd5;
	localparam logic [4:0] S_RS_RA  = 5'd6;
	localparam logic [4:0] S_RS_RB  = 5'd7;
	localparam logic [4:0] S_RS_W   = 5'd8;
	localparam logic [4:0] S_RS_CMP = 5'd9;
	localparam logic [4:0] S_DN_RA  = 5'd10;
	localparam logic [4:0] S_DN_RL  = 5'd11;
	localparam logic [4:0] S_DN_RR  = 5'd12;
	localparam logic [4:0] S_DN_W   = 5'd13;
	localparam logic [4:0] S_DN_CMP = 5'd14;
	localparam logic [4:0] S_SW_R1  = 5'd15;
	localparam logic [4:0] S_SW_R2  = 5'd16;
	localparam logic [4:0] S_SW_W0  = 5'd17;
	localparam logic [4:0] S_SW_L1  = 5'd18;
	localparam logic [4:0] S_SW_L2  = 5'd19;
	localparam logic [4:0] S_SW_L3  = 5'd20;
	localparam logic [4:0] S_SW_L4  = 5'd21;
	localparam logic [4:0] S_SW_R3  = 5'd22;
	localparam logic [4:0] S_SW_R4  = 5'd23;
	localparam logic [4:0] S_SW_W1  = 5'd24;
	localparam logic [4:0] S_SW_X1  = 5'd25;
	localparam logic [4:0] S_SW_X2  = 5'd26;
	localparam logic [4:0] S_FIN    = 5'd27;
	localparam logic [4:0] S_FIN_W  = 5'd28;
	localparam logic [4:0] S_FIN_O  = 5'd29;

	localparam logic [1:0] RET_UP  = 2'd0;
	localparam logic [1:0] RET_DN  = 2'd1;
	localparam logic [1:0] RET_FIN = 2'd2;

	logic [4:0] state_q, state_d;
	logic [1:0] ret_q, ret_d;
	logic       out_vld_q;
	logic       out_free;

	assign out_free = ~out_vld_q | m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;

	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		cmd.op       = lmh_pkg::OP_NONE;
		cmd.rsel     = lmh_pkg::RS_CUR;
		cmd.dst      = lmh_pkg::DST_A;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = lmh_pkg::OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				case (stat.cmd)
					lmh_pkg::CMD_WRITE:   cmd.op = lmh_pkg::OP_WR_ENTRY;
					lmh_pkg::CMD_SETKEY:  cmd.op = lmh_pkg::OP_WR_KEY;
					lmh_pkg::CMD_SETLINK: cmd.op = lmh_pkg::OP_WR_LINKS;
					lmh_pkg::CMD_SIFTUP: begin
						if (!stat.n_zero) begin
							cmd.op  = lmh_pkg::OP_SET_LAST;
							state_d = S_UP_RA;
						end
					end
					lmh_pkg::CMD_RESTORE: begin
						if (stat.pos_lt_n) state_d = S_RS_RA;
					end
					default: ;
				endcase
			end
			S_UP_RA: begin
				if (stat.cur_zero) state_d = S_FIN;
				else begin
					cmd.op  = lmh_pkg::OP_READ;
					state_d = S_UP_RB;
				end
			end
			S_UP_RB: begin
				cmd.op   = lmh_pkg::OP_READ;
				cmd.rsel = lmh_pkg::RS_PAR;
				cmd.dst  = lmh_pkg::DST_B;
				state_d  = S_UP_W;
			end
			S_UP_W: state_d = S_UP_CMP;
			S_UP_CMP: begin
				// equal keys still swap on the way up
				if (stat.a_gt_b) state_d = S_FIN;
				else begin
					cmd.op  = lmh_pkg::OP_OTH_PAR;
					ret_d   = RET_UP;
					state_d = S_SW_R1;
				end
			end
			S_RS_RA: begin
				if (stat.cur_zero) state_d = S_DN_RA;
				else begin
					cmd.op  = lmh_pkg::OP_READ;
					state_d = S_RS_RB;
				end
			end
			S_RS_RB: begin
				cmd.op   = lmh_pkg::OP_READ;
				cmd.rsel = lmh_pkg::RS_PAR;
				cmd.dst  = lmh_pkg::DST_B;
				state_d  = S_RS_W;
			end
			S_RS_W: state_d = S_RS_CMP;
			S_RS_CMP: state_d = stat.a_lt_b ? S_UP_CMP : S_DN_RA;
			S_DN_RA: begin
				if (!stat.left_lt_n) state_d = S_FIN;
				else begin
					cmd.op  = lmh_pkg::OP_READ;
					state_d = S_DN_RL;
				end
			end
			S_DN_RL: begin
				cmd.op   = lmh_pkg::OP_READ;
				cmd.rsel = lmh_pkg::RS_LEFT;
				cmd.dst  = lmh_pkg::DST_L;
				state_d  = S_DN_RR;
			end
			S_DN_RR: begin
				if (stat.right_lt_n) begin
					cmd.op   = lmh_pkg::OP_READ;
					cmd.rsel = lmh_pkg::RS_RIGHT;
					cmd.dst  = lmh_pkg::DST_R;
				end
				state_d = S_DN_W;
			end
			S_DN_W: state_d = S_DN_CMP;
			S_DN_CMP: begin
				state_d = S_FIN;
				ret_d   = RET_DN;
				if (!stat.right_lt_n) begin
					// lone left child: at most one swap, then done
					if (stat.a_gt_l) begin
						cmd.op  = lmh_pkg::OP_OTH_L;
						ret_d   = RET_FIN;
						state_d = S_SW_R1;
					end
				end else if (!stat.a_gt_l) begin
					if (stat.a_gt_r) begin
						cmd.op  = lmh_pkg::OP_OTH_R;
						state_d = S_SW_R1;
					end
				end else begin
					cmd.op  = stat.l_lt_r ? lmh_pkg::OP_OTH_L : lmh_pkg::OP_OTH_R;
					state_d = S_SW_R1;
				end
			end
			S_SW_R1: begin
				cmd.op  = lmh_pkg::OP_READ;
				state_d = S_SW_R2;
			end
			S_SW_R2: begin
				cmd.op   = lmh_pkg::OP_READ;
				cmd.rsel = lmh_pkg::RS_OTH;
				cmd.dst  = lmh_pkg::DST_B;
				state_d  = S_SW_W0;
			end
			S_SW_W0: state_d = S_SW_L1;
			S_SW_L1: begin
				cmd.op  = lmh_pkg::OP_LNK1;
				state_d = S_SW_L2;
			end
			S_SW_L2: begin
				cmd.op  = lmh_pkg::OP_LNK2;
				state_d = S_SW_L3;
			end
			S_SW_L3: begin
				cmd.op  = lmh_pkg::OP_LNK3;
				state_d = S_SW_L4;
			end
			S_SW_L4: begin
				cmd.op  = lmh_pkg::OP_LNK4;
				state_d = S_SW_R3;
			end
			// re-read both entries: the redirects may have touched them
			S_SW_R3: begin
				cmd.op  = lmh_pkg::OP_READ;
				state_d = S_SW_R4;
			end
			S_SW_R4: begin
				cmd.op   = lmh_pkg::OP_READ;
				cmd.rsel = lmh_pkg::RS_OTH;
				cmd.dst  = lmh_pkg::DST_B;
				state_d  = S_SW_W1;
			end
			S_SW_W1: state_d = S_SW_X1;
			S_SW_X1: begin
				cmd.op  = lmh_pkg::OP_XCHG1;
				state_d = S_SW_X2;
			end
			S_SW_X2: begin
				cmd.op = lmh_pkg::OP_XCHG2;
				case (ret_q)
					RET_UP:  state_d = S_UP_RA;
					RET_DN:  state_d = S_DN_RA;
					default: state_d = S_FIN;
				endcase
			end
			S_FIN: begin
				cmd.op  = lmh_pkg::OP_READ;
				state_d = S_FIN_W;
			end
			S_FIN_W: state_d = S_FIN_O;
			S_FIN_O: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= RET_FIN;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

endmodule

>>> sv/linked_min_heap.sv
// Top level of the linked min-heap: stream ports, sequencer and datapath.
// Depends on lmh_pkg, lmh_ctrl and lmh_dp.
//
//  channel  | dir | fields (low bit first)
//  s_t*     | in  | cmd, position, heap_size, key_in, payload_in, prev_in, next_in
//  m_t*     | out | key_out, payload_out, prev_out, next_out, final_position
//
// One item at a time. Reads and writes load the item, dispatch it, read the
// entry back and offer the result; a sift adds, per level up or down, the
// compare reads and a swap of the two entries. One memory access per cycle
// sets the pace. Reset clears control only; memory contents are undefined
// until written. A held result does not block the next transfer in.
module linked_min_heap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// cmd[2:0] position[12:3] heap_size[23:13] key_in[47:24]
	// payload_in[111:48] prev_in[122:112] next_in[133:123], zero fill
	input  logic [lmh_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// key_out[23:0] payload_out[87:24] prev_out[98:88] next_out[109:99]
	// final_position[119:110]
	output logic [lmh_pkg::OUT_W-1:0]  m_tdata
);

	lmh_pkg::lmh_cmd_t  cmd;
	lmh_pkg::lmh_stat_t stat;

	lmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lmh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (m_tdata)
	);

endmodule
